// File: hw/rtl/sqd_pkg.sv
// ----------------------------------------------------------------------------
// sqd_pkg
// Shared sizes, types and packing constants for the shortest-queue dispatcher.
// ----------------------------------------------------------------------------
package sqd_pkg;

   localparam int NUM_SERVERS = 4;
   localparam int QUEUE_DEPTH = 16;
   localparam int TIME_BITS   = 16;

   localparam int SRV_W   = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
   localparam int PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int OCC_W   = $clog2(NUM_SERVERS * QUEUE_DEPTH + 1);
   localparam int INC_W   = $clog2(NUM_SERVERS + 1);
   localparam int WSUM_W  = TIME_BITS + INC_W;
   localparam int SVC_W   = 8;
   localparam int CFG_W   = 3;
   localparam int ACT_W   = CFG_W + 1;

   // Stream payload widths
   localparam int REQ_W   = 40;
   localparam int RSP_W   = 160;

   // Result field widths
   localparam int TICK_W  = 16;
   localparam int JOIN_W  = 2;
   localparam int START_W = 4;
   localparam int QNOW_W  = 7;
   localparam int SERV_W  = 32;
   localparam int TOT_W   = 48;

   typedef logic [TIME_BITS-1:0] stamp_type;
   typedef logic [CNT_W-1:0]     cnt_type;

   typedef struct packed {
      logic started;
      logic bypass;
   } lane_status_type;

   // Dispatch stage result, waiting for the lanes' head stamps
   typedef struct packed {
      logic [TICK_W-1:0]      tick;
      logic [JOIN_W-1:0]      joined;
      logic                   dropped;
      logic [NUM_SERVERS-1:0] started;
      logic [NUM_SERVERS-1:0] bypass;
      logic [OCC_W-1:0]       occ;
      stamp_type              now;
   } stage1_type;

   // Reduced stage result, ready for the running totals
   typedef struct packed {
      logic [TICK_W-1:0]      tick;
      logic [JOIN_W-1:0]      joined;
      logic                   dropped;
      logic [NUM_SERVERS-1:0] started;
      logic [OCC_W-1:0]       occ;
      logic [WSUM_W-1:0]      wait_add;
      logic [INC_W-1:0]       served_inc;
   } stage2_type;

endpackage

// File: hw/rtl/sqd_lane.sv
// ----------------------------------------------------------------------------
// sqd_lane
// One server: its timestamp FIFO, occupancy, head pointer and service timer.
// ----------------------------------------------------------------------------
module sqd_lane (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step_en,
   input  logic                          active,
   input  logic                          push,
   input  sqd_pkg::stamp_type            now,
   input  logic [sqd_pkg::SVC_W-1:0]     svc_load,
   output sqd_pkg::cnt_type              count,
   output sqd_pkg::cnt_type              count_next,
   output sqd_pkg::lane_status_type      status,
   output sqd_pkg::stamp_type            head_stamp
);

   localparam int SUM_W = sqd_pkg::CNT_W + 1;

   sqd_pkg::cnt_type                  cnt_ff, cnt_in, cnt_mid;
   logic [sqd_pkg::PTR_W-1:0]         head_ff, head_in, slot_idx;
   logic [sqd_pkg::SVC_W-1:0]         svc_ff, svc_in;
   logic [SUM_W-1:0]                  slot_sum, slot_wrap;
   logic                              pop;
   sqd_pkg::stamp_type                queue_mem_ff [sqd_pkg::QUEUE_DEPTH];
   sqd_pkg::stamp_type                stamp_ff;

   // Tail slot of the circular buffer
   assign slot_sum  = SUM_W'(head_ff) + SUM_W'(cnt_ff);
   assign slot_wrap = (slot_sum >= SUM_W'(sqd_pkg::QUEUE_DEPTH))
                      ? slot_sum - SUM_W'(sqd_pkg::QUEUE_DEPTH) : slot_sum;
   assign slot_idx  = slot_wrap[sqd_pkg::PTR_W-1:0];

   // Push comes first, so an empty queue can serve the arrival in the same tick
   assign cnt_mid = cnt_ff + sqd_pkg::CNT_W'(push);
   assign pop     = active && (svc_ff == '0) && (cnt_mid != '0);

   always_comb begin
      cnt_in  = cnt_mid - sqd_pkg::CNT_W'(pop);
      head_in = head_ff;
      if (pop) begin
         head_in = (head_ff == sqd_pkg::PTR_W'(sqd_pkg::QUEUE_DEPTH - 1))
                   ? '0 : head_ff + 1'b1;
      end
      svc_in = svc_ff;
      if (active) begin
         if (svc_ff != '0) begin
            svc_in = svc_ff - 1'b1;
         end else if (pop) begin
            svc_in = svc_load;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         head_ff <= '0;
         svc_ff  <= '0;
      end else if (step_en) begin
         cnt_ff  <= cnt_in;
         head_ff <= head_in;
         svc_ff  <= svc_in;
      end
   end

   // Write the tail and read the head; a same-cycle collision is bypassed later
   always_ff @(posedge clock) begin
      if (step_en && push) begin
         queue_mem_ff[slot_idx] <= now;
      end
      if (step_en && pop) begin
         stamp_ff <= queue_mem_ff[head_ff];
      end
   end

   assign count          = cnt_ff;
   assign count_next     = cnt_in;
   assign status.started = pop;
   assign status.bypass  = pop && (cnt_ff == '0);
   assign head_stamp     = stamp_ff;

endmodule

// File: hw/rtl/sqd_merge.sv
// ----------------------------------------------------------------------------
// sqd_merge
// Combine the lanes' waits, update the saturating totals, hold the result.
// ----------------------------------------------------------------------------
module sqd_merge (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              st1_valid,
   input  sqd_pkg::stage1_type               st1,
   input  sqd_pkg::stamp_type                head_stamp [sqd_pkg::NUM_SERVERS],
   output logic                              st1_ready,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [sqd_pkg::RSP_W-1:0]         rsp_tdata
);

   localparam int SERV_SUM_W = sqd_pkg::SERV_W + 1;
   localparam int TOT_SUM_W  = sqd_pkg::TOT_W + 1;

   logic                              v2_ff, v2_in, out_v_ff, out_v_in;
   logic                              out_ready, adv_b, adv_c;
   sqd_pkg::stage2_type               st2_ff, st2_in;
   sqd_pkg::stamp_type                lane_wait;

   logic [sqd_pkg::TICK_W-1:0]        tick_ff;
   logic [sqd_pkg::JOIN_W-1:0]        joined_ff;
   logic                              dropped_ff;
   logic [sqd_pkg::START_W-1:0]       started_ff;
   logic [sqd_pkg::QNOW_W-1:0]        queued_ff, queued_in;
   logic [sqd_pkg::SERV_W-1:0]        served_ff, served_in;
   logic [sqd_pkg::TOT_W-1:0]         wait_ff, wait_in, length_ff, length_in;
   logic [SERV_SUM_W-1:0]             served_sum;
   logic [TOT_SUM_W-1:0]              wait_sum, length_sum;

   assign out_ready = !out_v_ff || rsp_tready;
   assign adv_c     = v2_ff && out_ready;
   assign st1_ready = !v2_ff || out_ready;
   assign adv_b     = st1_valid && st1_ready;

   // Stage B: per-lane wait, then sum across lanes
   always_comb begin
      st2_in.tick       = st1.tick;
      st2_in.joined     = st1.joined;
      st2_in.dropped    = st1.dropped;
      st2_in.started    = st1.started;
      st2_in.occ        = st1.occ;
      st2_in.wait_add   = '0;
      st2_in.served_inc = '0;
      lane_wait         = '0;
      for (int k = 0; k < sqd_pkg::NUM_SERVERS; k++) begin
         lane_wait = '0;
         if (st1.started[k] && !st1.bypass[k]) begin
            lane_wait = st1.now - head_stamp[k];
         end
         st2_in.wait_add   = st2_in.wait_add + sqd_pkg::WSUM_W'(lane_wait);
         st2_in.served_inc = st2_in.served_inc + sqd_pkg::INC_W'(st1.started[k]);
      end
   end

   assign v2_in = adv_b ? 1'b1 : (adv_c ? 1'b0 : v2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_b) begin
         st2_ff <= st2_in;
      end
   end

   // Stage C: saturating accumulation
   always_comb begin
      served_sum = SERV_SUM_W'(served_ff) + SERV_SUM_W'(st2_ff.served_inc);
      wait_sum   = TOT_SUM_W'(wait_ff) + TOT_SUM_W'(st2_ff.wait_add);
      length_sum = TOT_SUM_W'(length_ff) + TOT_SUM_W'(st2_ff.occ);
      served_in  = served_sum[SERV_SUM_W-1] ? '1 : served_sum[sqd_pkg::SERV_W-1:0];
      wait_in    = wait_sum[TOT_SUM_W-1] ? '1 : wait_sum[sqd_pkg::TOT_W-1:0];
      length_in  = length_sum[TOT_SUM_W-1] ? '1 : length_sum[sqd_pkg::TOT_W-1:0];
      queued_in  = (32'(st2_ff.occ) > 32'd127) ? 7'd127 : sqd_pkg::QNOW_W'(st2_ff.occ);
   end

   assign out_v_in = adv_c ? 1'b1 : (rsp_tready ? 1'b0 : out_v_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         served_ff <= '0;
         wait_ff   <= '0;
         length_ff <= '0;
      end else begin
         out_v_ff <= out_v_in;
         if (adv_c) begin
            served_ff <= served_in;
            wait_ff   <= wait_in;
            length_ff <= length_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv_c) begin
         tick_ff    <= st2_ff.tick;
         joined_ff  <= st2_ff.joined;
         dropped_ff <= st2_ff.dropped;
         started_ff <= sqd_pkg::START_W'(st2_ff.started);
         queued_ff  <= queued_in;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {2'b00, length_ff, wait_ff, served_ff, queued_ff,
                        started_ff, dropped_ff, joined_ff, tick_ff};

endmodule

// File: hw/rtl/shortest_queue_dispatch_servers.sv
// ----------------------------------------------------------------------------
// shortest_queue_dispatch_servers
// Join-shortest-queue dispatch of one arrival per tick onto per-server FIFOs.
// ----------------------------------------------------------------------------
//  port group   dir  payload
//  req_*        in   tdata[0] arrival, tdata[32:1] service_times (byte k = server k)
//  rsp_*        out  tdata: tick, joined queue, drop flag, starts, queue totals
//  csr_*        in   servers_in_use, written when csr_wr_en is high
//
//  One request per cycle unless the result side stalls; each result passes the
//  dispatch and lanes, lane reduction, and totals and output register stages.
//  Synchronous active-high reset clears all queues, timers and totals at once;
//  the queue memories need no clearing pass since only occupied slots are read.
//  A stalled result holds the output register; the stages behind it keep
//  filling until each is occupied, then req_tready drops.
// ----------------------------------------------------------------------------
module shortest_queue_dispatch_servers (
   input  logic                          clock,
   input  logic                          reset,
   // request stream
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [sqd_pkg::REQ_W-1:0]     req_tdata,   // [0] arrival, [32:1] service_times
   // result stream
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [sqd_pkg::RSP_W-1:0]     rsp_tdata,   // [15:0] tick_index, [17:16] joined_queue,
                                                      // [18] arrival_dropped,
                                                      // [22:19] services_started,
                                                      // [29:23] queued_now,
                                                      // [61:30] served_total,
                                                      // [109:62] wait_total,
                                                      // [157:110] length_total
   // configuration
   input  logic                          csr_wr_en,
   input  logic [sqd_pkg::CFG_W-1:0]     csr_wr_data  // servers_in_use
);

   logic [sqd_pkg::CFG_W-1:0]            servers_ff;
   logic [sqd_pkg::ACT_W-1:0]            n_active;
   logic [sqd_pkg::NUM_SERVERS-1:0]      act_mask, push_mask;
   sqd_pkg::stamp_type                   tick_ff;
   logic                                 arrival, step_en, st1_ready, v1_ff, v1_in;
   logic [31:0]                          service_times;
   logic [sqd_pkg::SRV_W-1:0]            best_idx;
   sqd_pkg::cnt_type                     best_cnt;
   logic                                 full;
   sqd_pkg::cnt_type                     lane_cnt      [sqd_pkg::NUM_SERVERS];
   sqd_pkg::cnt_type                     lane_cnt_next [sqd_pkg::NUM_SERVERS];
   sqd_pkg::lane_status_type             lane_status   [sqd_pkg::NUM_SERVERS];
   sqd_pkg::stamp_type                   head_stamp    [sqd_pkg::NUM_SERVERS];
   sqd_pkg::stage1_type                  st1_ff, st1_in;

   assign arrival       = req_tdata[0];
   assign service_times = req_tdata[32:1];

   // Hold the active server count; it should change only while idle, which the block itself does not enforce
   always_ff @(posedge clock) begin
      if (reset) begin
         servers_ff <= sqd_pkg::CFG_W'(1);
      end else if (csr_wr_en) begin
         servers_ff <= csr_wr_data;
      end
   end

   // Clamp to 1..NUM_SERVERS and expand to a prefix mask
   always_comb begin
      if (servers_ff == '0) begin
         n_active = sqd_pkg::ACT_W'(1);
      end else if (sqd_pkg::ACT_W'(servers_ff) > sqd_pkg::ACT_W'(sqd_pkg::NUM_SERVERS)) begin
         n_active = sqd_pkg::ACT_W'(sqd_pkg::NUM_SERVERS);
      end else begin
         n_active = sqd_pkg::ACT_W'(servers_ff);
      end
      for (int k = 0; k < sqd_pkg::NUM_SERVERS; k++) begin
         act_mask[k] = (sqd_pkg::ACT_W'(k) < n_active);
      end
   end

   // Pipeline handshake: accept whenever stage 1 is free or moving on
   assign req_tready = !v1_ff || st1_ready;
   assign step_en    = req_tvalid && req_tready;

   // Shortest active queue, lowest index on ties
   always_comb begin
      best_idx = '0;
      best_cnt = lane_cnt[0];
      for (int k = 1; k < sqd_pkg::NUM_SERVERS; k++) begin
         if (act_mask[k] && (lane_cnt[k] < best_cnt)) begin
            best_idx = sqd_pkg::SRV_W'(k);
            best_cnt = lane_cnt[k];
         end
      end
      full = (best_cnt >= sqd_pkg::CNT_W'(sqd_pkg::QUEUE_DEPTH));
      for (int k = 0; k < sqd_pkg::NUM_SERVERS; k++) begin
         push_mask[k] = arrival && !full && (best_idx == sqd_pkg::SRV_W'(k));
      end
   end

   for (genvar g = 0; g < sqd_pkg::NUM_SERVERS; g++) begin : g_lane
      sqd_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .step_en    (step_en),
         .active     (act_mask[g]),
         .push       (push_mask[g]),
         .now        (tick_ff),
         .svc_load   (service_times[8*(g%4) +: 8]),
         .count      (lane_cnt[g]),
         .count_next (lane_cnt_next[g]),
         .status     (lane_status[g]),
         .head_stamp (head_stamp[g])
      );
   end

   // Gather the lanes into the stage 1 record
   always_comb begin
      st1_in.tick    = sqd_pkg::TICK_W'(tick_ff);
      st1_in.joined  = arrival ? sqd_pkg::JOIN_W'(best_idx) : '0;
      st1_in.dropped = arrival && full;
      st1_in.now     = tick_ff;
      st1_in.occ     = '0;
      for (int k = 0; k < sqd_pkg::NUM_SERVERS; k++) begin
         st1_in.started[k] = lane_status[k].started;
         st1_in.bypass[k]  = lane_status[k].bypass;
         st1_in.occ        = st1_in.occ + sqd_pkg::OCC_W'(lane_cnt_next[k]);
      end
   end

   assign v1_in = step_en ? 1'b1 : (st1_ready ? 1'b0 : v1_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         tick_ff <= '0;
      end else begin
         v1_ff <= v1_in;
         if (step_en) begin
            tick_ff <= tick_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         st1_ff <= st1_in;
      end
   end

   sqd_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .st1_valid  (v1_ff),
      .st1        (st1_ff),
      .head_stamp (head_stamp),
      .st1_ready  (st1_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// File: hw/rtl/sqd_checker.sv
// ----------------------------------------------------------------------------
// sqd_checker
// Port-level checks on the dispatcher's result stream.
// ----------------------------------------------------------------------------
module sqd_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [sqd_pkg::RSP_W-1:0]     rsp_tdata
);

   logic                             seen_ff;
   logic [15:0]                      last_tick_ff;
   logic [31:0]                      last_served_ff;
   logic                             rsp_take;
   logic                             req_take;

   assign rsp_take = rsp_tvalid && rsp_tready;
   assign req_take = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else if (rsp_take) begin
         seen_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_take) begin
         last_tick_ff   <= rsp_tdata[15:0];
         last_served_ff <= rsp_tdata[61:30];
      end
   end

   // No result leaves in the cycle right after reset
   a_quiet_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("result shown right after reset");

   // A stalled result holds its payload
   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // Results come one per tick, in tick order, none lost or repeated
   a_tick_order: assert property (@(posedge clock) disable iff (reset)
      rsp_take && seen_ff |-> rsp_tdata[15:0] == 16'(last_tick_ff + 16'd1))
      else $error("tick index skipped or repeated");

   // The served total never goes backward
   a_served_grows: assert property (@(posedge clock) disable iff (reset)
      rsp_take && seen_ff |-> rsp_tdata[61:30] >= last_served_ff)
      else $error("served total decreased");

   // If the first cycle out of reset accepts no request, no result follows it
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      $past(reset) && !req_take |=> !rsp_tvalid)
      else $error("result without request");

endmodule

bind shortest_queue_dispatch_servers sqd_checker u_sqd_checker (.*);

// File: tb/sv/tb_shortest_queue_dispatch_servers.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_shortest_queue_dispatch_servers
// Self-checking bench for the join-shortest-queue dispatcher. A driver sends
// one request per tick from a backlog that is built up front. A monitor runs
// a cycle-free model of the queues, timers and totals on every accepted
// request and compares each result, field by field, against the oldest
// prediction. Both stream sides idle in random bursts. The server count is
// changed only between phases, once every result is back.
// ----------------------------------------------------------------------------
module tb_shortest_queue_dispatch_servers;

   localparam int SETTLE_CYCLES  = 6;     // quiet cycles before a csr write
   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no traffic at all

   typedef enum logic {ITEM_TICK, ITEM_SERVERS} backlog_kind_type;
   typedef enum int {SVC_SHORT, SVC_LONG, SVC_MIXED} svc_mix_type;

   typedef struct {
      backlog_kind_type          kind;
      logic                      arrival;
      logic [31:0]               svc_times;
      logic [sqd_pkg::CFG_W-1:0] servers;
      int unsigned               idle_pct;
   } backlog_item_type;

   typedef struct {
      logic [sqd_pkg::TICK_W-1:0]  tick_idx;
      logic [sqd_pkg::JOIN_W-1:0]  joined_q;
      logic                        dropped;
      logic [sqd_pkg::START_W-1:0] started;
      logic [sqd_pkg::QNOW_W-1:0]  queued;
      logic [sqd_pkg::SERV_W-1:0]  served;
      logic [sqd_pkg::TOT_W-1:0]   waited;
      logic [sqd_pkg::TOT_W-1:0]   occ_sum;
   } tick_report_type;

   // DUT ports; every input holds a known value from time zero
   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [sqd_pkg::REQ_W-1:0] req_tdata = '0;    // [0] arrival, [32:1] service_times
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [sqd_pkg::RSP_W-1:0] rsp_tdata;        // tick, joined, dropped, starts, queued,
                                                // served, wait total, length total
   logic                      csr_wr_en = 1'b0;
   logic [sqd_pkg::CFG_W-1:0] csr_wr_data = '0;

   // Model state: one FIFO of arrival stamps per server plus a service timer
   logic [sqd_pkg::CFG_W-1:0]     srv_setting;
   logic [sqd_pkg::TIME_BITS-1:0] tick_now;
   logic [sqd_pkg::TIME_BITS-1:0] q_stamp [sqd_pkg::NUM_SERVERS][sqd_pkg::QUEUE_DEPTH];
   int unsigned                   q_head   [sqd_pkg::NUM_SERVERS];
   int unsigned                   q_count  [sqd_pkg::NUM_SERVERS];
   int unsigned                   svc_left [sqd_pkg::NUM_SERVERS];
   logic [sqd_pkg::SERV_W-1:0]    served_acc;
   logic [sqd_pkg::TOT_W-1:0]     wait_acc;
   logic [sqd_pkg::TOT_W-1:0]     occ_acc;

   backlog_item_type tick_backlog [$];   // ticks and csr writes not yet sent
   tick_report_type  reports_due  [$];   // predicted results, oldest first

   // Driver and sink bookkeeping
   logic        send_valid;
   logic        wr_now;
   logic        req_taken = 1'b0;
   int unsigned idle_left = 0;
   int unsigned stall_left = 0;
   int unsigned settle_cnt = 0;
   int unsigned cur_idle_pct = 0;

   // Run statistics
   int unsigned ticks_queued = 0;
   int unsigned ticks_checked = 0;
   int unsigned arrivals_seen = 0;
   int unsigned drops_seen = 0;
   int unsigned starts_seen = 0;
   int unsigned quiet_cycles = 0;
   int unsigned mismatches = 0;
   logic [7:0]  settings_seen = '0;

   shortest_queue_dispatch_servers u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Advance the model by one tick and return the result it should report.
   // Join first, then let every active server count down or pop its head.
   function automatic tick_report_type serve_one_tick(input logic arrive,
                                                      input logic [31:0] svc);
      int unsigned                   n_act;
      int unsigned                   pick;
      int unsigned                   slot;
      int unsigned                   occ;
      logic [sqd_pkg::TIME_BITS-1:0] age;
      logic [sqd_pkg::TOT_W:0]       acc;
      tick_report_type               rep;
      // a setting of zero acts as one server, anything above the max as the max
      n_act = (srv_setting == 0) ? 1 :
              ((srv_setting > sqd_pkg::NUM_SERVERS) ? sqd_pkg::NUM_SERVERS : srv_setting);
      pick = 0;
      rep.dropped = 1'b0;
      rep.started = '0;
      if (arrive) begin
         // shortest active queue, lowest index on a tie
         for (int k = 1; k < n_act; k++) begin
            if (q_count[k] < q_count[pick]) pick = k;
         end
         if (q_count[pick] >= sqd_pkg::QUEUE_DEPTH) begin
            rep.dropped = 1'b1;
         end else begin
            slot = (q_head[pick] + q_count[pick]) % sqd_pkg::QUEUE_DEPTH;
            q_stamp[pick][slot] = tick_now;
            q_count[pick]++;
         end
      end
      // inactive servers keep their queues and timers frozen
      for (int k = 0; k < n_act; k++) begin
         if (svc_left[k] > 0) begin
            svc_left[k]--;
         end else if (q_count[k] > 0) begin
            age = tick_now - q_stamp[k][q_head[k]];   // wraps with the tick counter
            q_head[k] = (q_head[k] + 1) % sqd_pkg::QUEUE_DEPTH;
            q_count[k]--;
            acc = {1'b0, wait_acc} + age;
            wait_acc = acc[sqd_pkg::TOT_W] ? '1 : acc[sqd_pkg::TOT_W-1:0];
            if (served_acc != '1) served_acc++;
            svc_left[k] = svc[8*(k%4) +: 8];
            rep.started[k] = 1'b1;
         end
      end
      occ = 0;
      for (int k = 0; k < sqd_pkg::NUM_SERVERS; k++) occ += q_count[k];
      acc = {1'b0, occ_acc} + occ;
      occ_acc = acc[sqd_pkg::TOT_W] ? '1 : acc[sqd_pkg::TOT_W-1:0];
      rep.tick_idx = tick_now;
      rep.joined_q = sqd_pkg::JOIN_W'(pick);
      rep.queued   = (occ > 127) ? 7'd127 : sqd_pkg::QNOW_W'(occ);
      rep.served   = served_acc;
      rep.waited   = wait_acc;
      rep.occ_sum  = occ_acc;
      tick_now++;
      return rep;
   endfunction

   function automatic void check_field(string name, longint unsigned want,
                                       longint unsigned got);
      if (want != got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         mismatches++;
      end
   endfunction

   function automatic logic [31:0] draw_service(svc_mix_type mix);
      logic [31:0] v;
      for (int b = 0; b < 4; b++) begin
         case (mix)
            SVC_SHORT: begin
               v[8*b +: 8] = 8'($urandom_range(3, 0));
            end
            SVC_LONG: begin
               v[8*b +: 8] = 8'($urandom_range(255, 0));
            end
            default: begin
               case ($urandom_range(2, 0))
                  0: v[8*b +: 8] = 8'd0;
                  1: v[8*b +: 8] = 8'($urandom_range(3, 0));
                  default: v[8*b +: 8] = 8'($urandom_range(255, 0));
               endcase
            end
         endcase
      end
      return v;
   endfunction

   task automatic push_tick(input logic arrive, input logic [31:0] svc,
                            input int unsigned idle);
      backlog_item_type it;
      it.kind      = ITEM_TICK;
      it.arrival   = arrive;
      it.svc_times = svc;
      it.servers   = '0;
      it.idle_pct  = idle;
      tick_backlog.push_back(it);
      ticks_queued++;
   endtask

   task automatic push_servers(input logic [sqd_pkg::CFG_W-1:0] value);
      backlog_item_type it;
      it.kind      = ITEM_SERVERS;
      it.arrival   = 1'b0;
      it.svc_times = '0;
      it.servers   = value;
      it.idle_pct  = 0;
      tick_backlog.push_back(it);
   endtask

   // One phase: a server count, then a run of random ticks
   task automatic queue_phase(input logic [sqd_pkg::CFG_W-1:0] servers,
                              input int unsigned count,
                              input int unsigned arrive_pct, input svc_mix_type mix,
                              input int unsigned idle);
      push_servers(servers);
      for (int i = 0; i < count; i++) begin
         push_tick($urandom_range(99, 0) < arrive_pct, draw_service(mix), idle);
      end
   endtask

   // Driver: present the backlog head at the falling edge. Hold a csr write
   // until no result is outstanding and the pipeline has had time to settle.
   always @(negedge clock) begin : drive_proc
      backlog_item_type head;
      if (reset) begin
         req_tvalid <= 1'b0;
         csr_wr_en  <= 1'b0;
      end else begin
         send_valid = req_tvalid;
         wr_now     = 1'b0;
         if (req_tvalid && req_taken) begin
            send_valid = 1'b0;
            // roll an idle burst before the next request
            if ($urandom_range(99, 0) < cur_idle_pct) idle_left = $urandom_range(14, 1);
         end
         if (!send_valid) begin
            if (idle_left > 0) begin
               idle_left--;
            end else if (tick_backlog.size() > 0) begin
               head = tick_backlog[0];
               if (head.kind == ITEM_SERVERS) begin
                  settle_cnt = (reports_due.size() == 0) ? settle_cnt + 1 : 0;
                  if (settle_cnt >= SETTLE_CYCLES) begin
                     wr_now = 1'b1;
                     csr_wr_data <= head.servers;
                     settle_cnt = 0;
                     void'(tick_backlog.pop_front());
                  end
               end else begin
                  send_valid = 1'b1;
                  req_tdata <= sqd_pkg::REQ_W'({head.svc_times, head.arrival});
                  cur_idle_pct = head.idle_pct;
                  void'(tick_backlog.pop_front());
               end
            end
         end
         req_tvalid <= send_valid;
         csr_wr_en  <= wr_now;
      end
   end

   // Sink: stall the result side in bursts; never stall when idling is off
   always @(negedge clock) begin : sink_proc
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(99, 0) < cur_idle_pct / 3) begin
         stall_left = $urandom_range(14, 1) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Monitor: predict on every accepted request, check every accepted result
   always @(posedge clock) begin : monitor_proc
      tick_report_type due;
      tick_report_type got;
      req_taken <= req_tvalid && req_tready;
      if (!reset) begin
         if (csr_wr_en) begin
            srv_setting = csr_wr_data;
            settings_seen[csr_wr_data] = 1'b1;
         end
         if (req_tvalid && req_tready) begin
            reports_due.push_back(serve_one_tick(req_tdata[0], req_tdata[32:1]));
            arrivals_seen += req_tdata[0];
         end
         if (rsp_tvalid && rsp_tready) begin
            got.tick_idx = rsp_tdata[15:0];
            got.joined_q = rsp_tdata[17:16];
            got.dropped  = rsp_tdata[18];
            got.started  = rsp_tdata[22:19];
            got.queued   = rsp_tdata[29:23];
            got.served   = rsp_tdata[61:30];
            got.waited   = rsp_tdata[109:62];
            got.occ_sum  = rsp_tdata[157:110];
            if (reports_due.size() == 0) begin
               $error("result for tick 0x%0h with no request outstanding", got.tick_idx);
               mismatches++;
            end else begin
               due = reports_due.pop_front();
               check_field("tick_index", due.tick_idx, got.tick_idx);
               check_field("joined_queue", due.joined_q, got.joined_q);
               check_field("arrival_dropped", due.dropped, got.dropped);
               check_field("services_started", due.started, got.started);
               check_field("queued_now", due.queued, got.queued);
               check_field("served_total", due.served, got.served);
               check_field("wait_total", due.waited, got.waited);
               check_field("length_total", due.occ_sum, got.occ_sum);
               ticks_checked++;
               drops_seen  += got.dropped;
               starts_seen += $countones(got.started);
            end
         end
         // watchdog: give up when nothing moves for too long
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
               $display("Timeout: no traffic for %0d cycles", WATCHDOG_LIMIT);
               $display("shortest_queue_dispatch_servers: mismatch");
               $finish;
            end
         end
      end
   end

   initial begin : stimulus_proc
      // model reset state; the block powers up with one active server
      srv_setting = sqd_pkg::CFG_W'(1);
      tick_now    = '0;
      served_acc  = '0;
      wait_acc    = '0;
      occ_acc     = '0;
      foreach (q_head[k]) begin
         q_head[k]   = 0;
         q_count[k]  = 0;
         svc_left[k] = 0;
      end

      // Directed: a setting of zero acts as one server. Fill queue 0 behind a
      // 255-tick service until arrivals drop, then one tick with no arrival.
      push_servers(0);
      for (int i = 0; i < 19; i++) push_tick(1'b1, 32'hFFFF_FFFF, 20);
      push_tick(1'b0, 32'h0000_0000, 20);
      // Four servers: arrivals skip the full queue and take the lowest empty
      // one; zero service times free a server on the next tick.
      push_servers(4);
      push_tick(1'b1, 32'h0000_0000, 20);
      push_tick(1'b1, 32'h0000_0000, 20);
      push_tick(1'b1, 32'hFFFF_FFFF, 20);
      push_tick(1'b0, 32'hFFFF_FFFF, 20);
      push_tick(1'b1, 32'h00FF_00FF, 20);

      // Random phases across every setting; shrink to one server after
      // filling all four queues so the others sit frozen for a while.
      queue_phase(4, 150, 95, SVC_LONG,  30);
      queue_phase(1, 120, 50, SVC_SHORT, 30);
      queue_phase(2, 120, 60, SVC_MIXED, 20);
      queue_phase(7, 150, 70, SVC_MIXED, 40);
      queue_phase(3, 120, 100, SVC_SHORT, 10);
      queue_phase(5, 100, 20, SVC_MIXED, 30);
      // closing stretch without any idling
      queue_phase(0, 80,  60, SVC_SHORT, 0);
      queue_phase(6, 120, 80, SVC_MIXED, 0);
      queue_phase(4, 100, 50, SVC_MIXED, 0);

      // hold reset, then release it on a falling edge
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // drain: every tick checked, then give the pipeline time to misbehave
      while (ticks_checked != ticks_queued) @(negedge clock);
      repeat (8) @(negedge clock);

      $display("Covered %0d ticks: %0d arrivals, %0d dropped, %0d service starts",
               ticks_checked, arrivals_seen, drops_seen, starts_seen);
      $display("Server settings written (bit k = value k): %b", settings_seen);
      if (mismatches == 0 && reports_due.size() == 0) begin
         $display("shortest_queue_dispatch_servers: match");
      end else begin
         $display("shortest_queue_dispatch_servers: mismatch");
      end
      $finish;
   end

endmodule
